FILE: src/rct_pkg.sv
// Package: shared widths, result codes and controller state type for the replay table.
`default_nettype none

package rct_pkg;

  // Table size default
  localparam int PEERS_DEF = 32;

  // Field widths
  localparam int KEY_W   = 48;
  localparam int NUM_W   = 32;
  localparam int ENTRY_W = KEY_W + NUM_W;

  // Result codes
  typedef enum logic [2:0] {
    OUT_REPLAY  = 3'd0,
    OUT_UPDATED = 3'd1,
    OUT_STORED  = 3'd2,
    OUT_DROPPED = 3'd3,
    OUT_CLEARED = 3'd4
  } outcome_t;

  // Item modes
  localparam logic MODE_CHECK = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

endpackage

`default_nettype wire

FILE: src/rct_if.sv
// Interfaces: input item channel and result channel of the replay table.
`default_nettype none

interface rct_in_if import rct_pkg::*;;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] sender_mac;
  logic [NUM_W-1:0] message_number;

  modport source (output valid, mode, sender_mac, message_number, input ready);
  modport sink   (input valid, mode, sender_mac, message_number, output ready);
endinterface

interface rct_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] outcome;

  modport source (output valid, accepted, outcome, input ready);
  modport sink   (input valid, accepted, outcome, output ready);
endinterface

`default_nettype wire

FILE: src/rct_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/replay_counter_table_top.sv
// Top level: replay filter controller scanning a sender table held in RAM.
// Scan: a check item reads the stored senders in turn (count = stored senders, at most
//   PEERS); a known sender ends the scan at its slot. A clear item skips the scan.
// Throughput: one item at a time; the next item is taken once the result is registered,
//   set by the single table read port scanning one entry per cycle.
// Reset: synchronous, clears the fill count, so the table is empty; no clearing pass.
`default_nettype none

module replay_counter_table_top import rct_pkg::*; #(
  parameter int PEERS = PEERS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  rct_in_if.sink   in_ch,
  rct_out_if.source out_ch
);

  localparam int AW = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CW = $clog2(PEERS + 1);

  // Registers
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rd_addr_r, rd_addr_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    pend_slot_r, pend_slot_nxt;
  logic             mode_r, mode_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic             found_r, found_nxt;
  logic [AW-1:0]    hit_slot_r, hit_slot_nxt;
  logic [NUM_W-1:0] hit_num_r, hit_num_nxt;
  logic             have_min_r, have_min_nxt;
  logic [KEY_W-1:0] min_key_r, min_key_nxt;
  logic [AW-1:0]    min_slot_r, min_slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_acc_r, out_acc_nxt;
  outcome_t         out_code_r, out_code_nxt;

  // RAM signals
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [NUM_W-1:0]   rd_num;

  logic in_xfer, hit, out_free;

  assign rd_key   = ram_rdata[ENTRY_W-1:NUM_W];
  assign rd_num   = ram_rdata[NUM_W-1:0];
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign hit      = pend_r && (rd_key == key_r);
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.accepted = out_acc_r;
  assign out_ch.outcome  = out_code_r;

  rct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PEERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: capture item, scan entries, decide and write back
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_addr_nxt   = rd_addr_r;
    pend_nxt      = 1'b0;
    pend_slot_nxt = pend_slot_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    num_nxt       = num_r;
    found_nxt     = found_r;
    hit_slot_nxt  = hit_slot_r;
    hit_num_nxt   = hit_num_r;
    have_min_nxt  = have_min_r;
    min_key_nxt   = min_key_r;
    min_slot_nxt  = min_slot_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_acc_nxt   = out_acc_r;
    out_code_nxt  = out_code_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = {key_r, num_r};
    ram_re        = 1'b0;
    ram_raddr     = rd_addr_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt     = in_ch.mode;
          key_nxt      = in_ch.sender_mac;
          num_nxt      = in_ch.message_number;
          rd_addr_nxt  = '0;
          found_nxt    = 1'b0;
          have_min_nxt = 1'b0;
          state_nxt    = (in_ch.mode == MODE_CLEAR) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // track smallest stored key among non-matching entries
        if (pend_r && !hit && (!have_min_r || rd_key < min_key_r)) begin
          have_min_nxt = 1'b1;
          min_key_nxt  = rd_key;
          min_slot_nxt = pend_slot_r;
        end
        if (hit) begin
          found_nxt    = 1'b1;
          hit_slot_nxt = pend_slot_r;
          hit_num_nxt  = rd_num;
          state_nxt    = ST_DECIDE;
        end else if (rd_addr_r < count_r) begin
          ram_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_slot_nxt = rd_addr_r[AW-1:0];
          rd_addr_nxt   = rd_addr_r + CW'(1);
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (mode_r == MODE_CLEAR) begin
            count_nxt    = '0;
            out_acc_nxt  = 1'b0;
            out_code_nxt = OUT_CLEARED;
          end else if (found_r) begin
            if (num_r > hit_num_r) begin
              ram_we       = 1'b1;
              ram_waddr    = hit_slot_r;
              out_acc_nxt  = 1'b1;
              out_code_nxt = OUT_UPDATED;
            end else begin
              out_acc_nxt  = 1'b0;
              out_code_nxt = OUT_REPLAY;
            end
          end else if (count_r < CW'(PEERS)) begin
            ram_we       = 1'b1;
            ram_waddr    = count_r[AW-1:0];
            count_nxt    = count_r + CW'(1);
            out_acc_nxt  = 1'b1;
            out_code_nxt = OUT_STORED;
          end else if (key_r < min_key_r) begin
            out_acc_nxt  = 1'b1;
            out_code_nxt = OUT_DROPPED;
          end else begin
            // replace the smallest stored key
            ram_we       = 1'b1;
            ram_waddr    = min_slot_r;
            out_acc_nxt  = 1'b1;
            out_code_nxt = OUT_STORED;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan bookkeeping
  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    pend_slot_r <= pend_slot_nxt;
    mode_r      <= mode_nxt;
    key_r       <= key_nxt;
    num_r       <= num_nxt;
    found_r     <= found_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_num_r   <= hit_num_nxt;
    have_min_r  <= have_min_nxt;
    min_key_r   <= min_key_nxt;
    min_slot_r  <= min_slot_nxt;
    out_acc_r   <= out_acc_nxt;
    out_code_r  <= out_code_nxt;
  end

  // Fill count never passes table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(PEERS))
    else $error("fill count exceeds table size");

  // A result is loaded only on leaving the decide step
  a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == ST_DECIDE))
    else $error("result loaded outside decide step");

  // A pending read only exists while scanning
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN))
    else $error("read pending outside scan");

  // Fill count changes only at the decide step
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> $past(state_r == ST_DECIDE))
    else $error("fill count changed outside decide step");

  // A transfer starts a scan or, for clear, the decide step
  a_xfer_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_SCAN) || (state_r == ST_DECIDE))
    else $error("transfer did not start processing");

endmodule

`default_nettype wire

FILE: sim/replay_counter_table_top_test.sv
// Testbench: random and directed traffic through the replay table, checked against a table model.
`timescale 1ns / 100ps

module replay_counter_table_top_test;
  import rct_pkg::*;

  localparam int          TABLE_SIZE = PEERS_DEF;
  localparam int          ITEM_GOAL  = 1850;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          SETTLE     = 2 * TABLE_SIZE + 8;
  localparam int          POOL_MAX   = 64;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct {
    logic     accepted;
    outcome_t outcome;
  } verdict_t;

  // Table model: predicts each verdict and keeps them in transfer order
  class replay_checker;
    logic             live   [TABLE_SIZE];
    logic [KEY_W-1:0] owner  [TABLE_SIZE];
    logic [NUM_W-1:0] newest [TABLE_SIZE];
    int unsigned      held;
    verdict_t         verdicts_due[$];
    int unsigned      faults;

    function new();
      clear_table();
      faults = 0;
    endfunction

    function void clear_table();
      foreach (live[i]) live[i] = 1'b0;
      held = 0;
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("%t ERROR %s", $realtime, msg);
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    // Last number stored for a sender, for the stimulus side
    function bit lookup(logic [KEY_W-1:0] mac, output logic [NUM_W-1:0] num);
      num = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (live[i] && owner[i] == mac) begin
          num = newest[i];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // Called on each input transfer: updates the table and queues the verdict
    function void judge_message(logic mode, logic [KEY_W-1:0] mac, logic [NUM_W-1:0] num);
      verdict_t v;
      int       free_slot;
      int       min_slot;
      free_slot = -1;
      min_slot  = -1;
      if (mode == MODE_CLEAR) begin
        clear_table();
        v = '{1'b0, OUT_CLEARED};
        verdicts_due.push_back(v);
        return;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
        if (live[i]) begin
          if (owner[i] == mac) begin
            if (num <= newest[i]) begin
              v = '{1'b0, OUT_REPLAY};
            end else begin
              newest[i] = num;
              v = '{1'b1, OUT_UPDATED};
            end
            verdicts_due.push_back(v);
            return;
          end
          if (min_slot < 0 || owner[i] < owner[min_slot]) min_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        live[free_slot]   = 1'b1;
        owner[free_slot]  = mac;
        newest[free_slot] = num;
        held++;
        v = '{1'b1, OUT_STORED};
      end else if (min_slot < 0 || mac < owner[min_slot]) begin
        // full table, new sender holds the smallest key
        v = '{1'b1, OUT_DROPPED};
      end else begin
        owner[min_slot]  = mac;
        newest[min_slot] = num;
        v = '{1'b1, OUT_STORED};
      end
      verdicts_due.push_back(v);
    endfunction

    // Called on each result transfer
    function void check_result(logic accepted, logic [2:0] outcome);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        flag($sformatf("result with none due: accepted=%0d outcome=%0d", accepted, outcome));
        return;
      end
      v = verdicts_due.pop_front();
      if (accepted !== v.accepted)
        flag($sformatf("accepted: expected %0d, got %0d", v.accepted, accepted));
      if (outcome !== v.outcome)
        flag($sformatf("outcome: expected %0d (%s), got %0d",
                       v.outcome, v.outcome.name(), outcome));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rct_in_if  in_ch ();
  rct_out_if out_ch ();

  replay_checker sb = new();

  int unsigned sent;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned idle_cycles;

  replay_counter_table_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.accepted, out_ch.outcome);
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%t watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("replay_counter_table_top regression: fail");
        $finish;
      end
    end
  end

  // Receiver: stall patterns, with a long hold-off every few segments
  initial begin
    int unsigned seg;
    int unsigned len;
    int unsigned style;
    out_ch.ready = 1'b0;
    seg = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      seg++;
      if (seg % 7 == 3) begin
        len = $urandom_range(300, 500);
        repeat (len) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        style = $urandom_range(0, 2);
        len   = $urandom_range(20, 200);
        for (int c = 0; c < len; c++) begin
          @(negedge clk);
          case (style)
            0: begin
              out_ch.ready <= 1'b1;
            end
            1: begin
              out_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_ch.ready <= (c % 4 != 0);
            end
          endcase
        end
      end
    end
  end

  // Offer one item and hold it until transfer
  task automatic send_item(logic mode, logic [KEY_W-1:0] mac, logic [NUM_W-1:0] num);
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.sender_mac     <= mac;
    in_ch.message_number <= num;
    do @(posedge clk); while (!in_ch.ready);
    sb.judge_message(mode, mac, num);
    sent++;
  endtask

  // Burst and gap pacing on the sender side
  task automatic pace();
    int unsigned gap;
    logic [63:0] junk;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
    repeat (gap) begin
      junk = {$urandom, $urandom};
      @(negedge clk);
      in_ch.valid          <= 1'b0;
      in_ch.mode           <= junk[63];
      in_ch.sender_mac     <= junk[47:0];
      in_ch.message_number <= junk[62:31];
    end
    burst_left = $urandom_range(1, 30);
  endtask

  // Sender pause until every queued verdict has been checked
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [KEY_W-1:0] pool[POOL_MAX];
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] mac;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] last;
    logic [32:0]      sum;
    logic [63:0]      r64;
    logic             mode;
    int unsigned      pool_size;
    int unsigned      key_style;
    int unsigned      len;
    int unsigned      pick;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_CHECK;
    in_ch.sender_mac     = '0;
    in_ch.message_number = '0;
    sent                 = 0;
    burst_left           = 0;
    gap_max              = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: clear on empty table, key and number extremes, replay cases
    send_item(MODE_CLEAR, 48'h5A5A_A5A5_0F0F, 32'hDEAD_BEEF);
    send_item(MODE_CHECK, '0, '0);                        // new sender
    send_item(MODE_CHECK, '0, '0);                        // equal number
    send_item(MODE_CHECK, '0, 32'd1);                     // larger number
    send_item(MODE_CHECK, '0, '0);                        // smaller number
    send_item(MODE_CHECK, KEY_MAX, NUM_MAX);
    send_item(MODE_CHECK, KEY_MAX, NUM_MAX);              // equal at top
    send_item(MODE_CHECK, KEY_MAX, NUM_MAX - 1);
    send_item(MODE_CHECK, 48'h0102_0304_0506, 32'h8000_0000);
    send_item(MODE_CHECK, 48'h0102_0304_0506, 32'h8000_0001);
    send_item(MODE_CHECK, 48'h8000_0000_0000, 32'h7FFF_FFFF);
    send_item(MODE_CLEAR, KEY_MAX, NUM_MAX);              // ignored fields all ones
    send_item(MODE_CHECK, KEY_MAX, '0);                   // known before clear, new now
    send_item(MODE_CHECK, '0, '0);
    drain();

    // Random phases over sender pools of varied size and key spread
    while (sent < ITEM_GOAL) begin
      case ($urandom_range(0, 5))
        0:       pool_size = 4;
        1:       pool_size = 16;
        2:       pool_size = TABLE_SIZE - 1;
        3:       pool_size = TABLE_SIZE;
        4:       pool_size = TABLE_SIZE + 8;
        default: pool_size = POOL_MAX;
      endcase
      key_style = $urandom_range(0, 2);
      r64  = {$urandom, $urandom};
      base = r64[47:0];
      for (int i = 0; i < POOL_MAX; i++) begin
        r64 = {$urandom, $urandom};
        case (key_style)
          0:       pool[i] = r64[47:0];
          1:       pool[i] = KEY_W'($urandom_range(0, 255));
          default: pool[i] = {r64[7:0], base[39:0]};
        endcase
      end
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 12;
      endcase
      burst_left = 0;
      len = $urandom_range(60, 250);
      // last phase stops at the item goal
      if (len > ITEM_GOAL - sent) len = ITEM_GOAL - sent;

      repeat (len) begin
        pick = $urandom_range(0, 99);
        mode = MODE_CHECK;
        r64  = {$urandom, $urandom};
        if (pick == 0) begin
          mode = MODE_CLEAR;
          mac  = r64[47:0];
          num  = $urandom;
        end else if (pick < 7) begin
          // sender outside the pool
          mac = r64[47:0];
          num = $urandom;
        end else begin
          mac  = pool[$urandom_range(0, pool_size - 1)];
          pick = $urandom_range(0, 99);
          if (sb.lookup(mac, last)) begin
            if (pick < 60) begin
              sum = {1'b0, last} + 33'($urandom_range(1, (pick < 50) ? 16 : 32'hFFFF));
              num = sum[32] ? NUM_MAX : sum[31:0];
            end else if (pick < 72) begin
              num = last;
            end else if (pick < 82) begin
              num = (last == 0) ? '0 : NUM_W'($urandom_range(0, last - 1));
            end else begin
              num = $urandom;
            end
          end else begin
            if (pick < 10)      num = '0;
            else if (pick < 20) num = NUM_MAX;
            else                num = $urandom;
          end
        end
        send_item(mode, mac, num);
        pace();
      end

      if ($urandom_range(0, 2) == 0) drain();
    end

    // Wind down
    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) sb.flag($sformatf("%0d verdicts never arrived", sb.pending()));
    if (sb.faults == 0) begin
      $display("replay_counter_table_top regression: pass");
    end else begin
      $display("replay_counter_table_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rct_pkg.sv
src/rct_if.sv
src/rct_ram.sv
src/replay_counter_table_top.sv
sim/replay_counter_table_top_test.sv
